/* sv/fbc_pkg.sv */
// Shared types, widths and plane construction rules for the frustum box cull block.
package fbc_pkg;

  localparam int NUM_PLANES    = 6;
  localparam int RULE_PLANES   = 6;
  localparam int ACTIVE_PLANES = (NUM_PLANES < RULE_PLANES) ? NUM_PLANES : RULE_PLANES;
  localparam int PLANE_IDX_W   = (ACTIVE_PLANES > 1) ? $clog2(ACTIVE_PLANES) : 1;

  localparam int NUM_COEFS   = 4;
  localparam int ENTRY_W     = 32;
  localparam int COEF_W      = ENTRY_W + 1;
  localparam int COORD_W     = 16;
  localparam int PROD_W      = COEF_W + COORD_W;
  localparam int ACC_W       = PROD_W + 3;
  localparam int COL_IDX_W   = 2;
  localparam int TERM_W      = 3;

  localparam logic [TERM_W-1:0] TERM_D    = TERM_W'(3);
  localparam logic [TERM_W-1:0] TERM_LAST = TERM_W'(4);

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TEST = 1'b1;

  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  // Row of the clip matrix that a plane combines with the w row.
  function automatic logic [1:0] plane_row(input int p);
    logic [1:0] r;
    case (p)
      0, 1:    r = 2'd0;
      2, 3:    r = 2'd1;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

  // True where the plane adds the row to w, false where it subtracts it.
  function automatic logic plane_add(input int p);
    logic a;
    case (p)
      1, 2, 5: a = 1'b1;
      default: a = 1'b0;
    endcase
    return a;
  endfunction

endpackage

/* sv/fbc_if.sv */
// Handshake channels for the frustum box cull block: request word and result word.
interface fbc_in_if;
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [1:0]             column_index;
  fbc_pkg::entry_t        col_entry_0;
  fbc_pkg::entry_t        col_entry_1;
  fbc_pkg::entry_t        col_entry_2;
  fbc_pkg::entry_t        col_entry_3;
  fbc_pkg::coord_t        box_min_x;
  fbc_pkg::coord_t        box_min_y;
  fbc_pkg::coord_t        box_min_z;
  fbc_pkg::coord_t        box_max_x;
  fbc_pkg::coord_t        box_max_y;
  fbc_pkg::coord_t        box_max_z;

  modport source (
    output valid, req_type, column_index,
    output col_entry_0, col_entry_1, col_entry_2, col_entry_3,
    output box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    input  ready
  );
  modport sink (
    input  valid, req_type, column_index,
    input  col_entry_0, col_entry_1, col_entry_2, col_entry_3,
    input  box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

interface fbc_out_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface

/* sv/frustum_box_cull.sv */
// Frustum box cull top level: plane loading and sequenced box test on a shared multiplier.
//
//   channel  dir  fields
//   in_ch    in   req_type, column_index, col_entry_0..3, box_min_x..z, box_max_x..z
//   out_ch   out  visible (one word per box test, none per column load)
//
// A column load writes one coefficient of every plane at once.
// A box test runs the planes in turn on the single 33x16 multiply-accumulate unit,
// stops early when a plane rejects the box, and then posts the result.
// Reset clears all plane coefficients to zero. in_ch.ready is low while a test runs.
// A finished result waits in the output register while the next word can be taken.

module frustum_box_cull (
  input  logic       clk,
  input  logic       rst_n,
  fbc_in_if.sink     in_ch,
  fbc_out_if.source  out_ch
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

  state_t                             state_r, state_nxt;
  logic [fbc_pkg::PLANE_IDX_W-1:0]    plane_r, plane_nxt;
  logic [fbc_pkg::TERM_W-1:0]         term_r, term_nxt;
  fbc_pkg::acc_t                      acc_r, acc_nxt;
  fbc_pkg::prod_t                     prod_r, prod_nxt;
  logic                               nz_r, nz_nxt;
  logic                               vis_r, vis_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic                               out_visible_r, out_visible_nxt;
  fbc_pkg::coord_t                    lo_r [3];
  fbc_pkg::coord_t                    hi_r [3];

  logic                               in_accept;
  logic                               load_en;
  fbc_pkg::entry_t                    col_entry [fbc_pkg::NUM_COEFS];
  fbc_pkg::coef_t                     coef_rd;
  fbc_pkg::coord_t                    lo_sel, hi_sel, operand;
  fbc_pkg::acc_t                      dist_sum;
  logic                               plane_pass;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign load_en     = in_accept && (in_ch.req_type == fbc_pkg::REQ_LOAD);

  assign col_entry[0] = in_ch.col_entry_0;
  assign col_entry[1] = in_ch.col_entry_1;
  assign col_entry[2] = in_ch.col_entry_2;
  assign col_entry[3] = in_ch.col_entry_3;

  fbc_coef_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (load_en),
    .wr_col   (in_ch.column_index),
    .wr_entry (col_entry),
    .rd_plane (plane_r),
    .rd_term  (term_r[fbc_pkg::COL_IDX_W-1:0]),
    .rd_coef  (coef_rd)
  );

  // The corner nearest the positive side takes the larger coordinate where the
  // coefficient is non-negative and the smaller one otherwise.
  always_comb begin
    lo_sel  = '0;
    hi_sel  = '0;
    operand = fbc_pkg::COORD_W'(1);
    case (term_r)
      3'd0, 3'd1, 3'd2: begin
        lo_sel = lo_r[term_r[1:0]];
        hi_sel = hi_r[term_r[1:0]];
        if (coef_rd[fbc_pkg::COEF_W-1]) begin
          operand = (lo_sel < hi_sel) ? lo_sel : hi_sel;
        end else begin
          operand = (lo_sel > hi_sel) ? lo_sel : hi_sel;
        end
      end
      default: operand = fbc_pkg::COORD_W'(1);
    endcase
  end

  assign dist_sum   = acc_r + fbc_pkg::ACC_W'(prod_r);
  assign plane_pass = nz_r && (dist_sum > 0);

  always_comb begin
    state_nxt       = state_r;
    plane_nxt       = plane_r;
    term_nxt        = term_r;
    acc_nxt         = acc_r;
    prod_nxt        = prod_r;
    nz_nxt          = nz_r;
    vis_nxt         = vis_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_visible_nxt = out_visible_r;

    case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_ch.req_type == fbc_pkg::REQ_TEST)) begin
          state_nxt = ST_RUN;
          plane_nxt = '0;
          term_nxt  = '0;
        end
      end
      ST_RUN: begin
        prod_nxt = fbc_pkg::PROD_W'(coef_rd) * fbc_pkg::PROD_W'(operand);
        if (term_r == '0) begin
          acc_nxt = '0;
          nz_nxt  = (coef_rd != '0);
        end else begin
          acc_nxt = dist_sum;
          if (term_r < fbc_pkg::TERM_D) begin
            nz_nxt = nz_r || (coef_rd != '0);
          end
        end
        if (term_r == fbc_pkg::TERM_LAST) begin
          term_nxt = '0;
          if (!plane_pass) begin
            vis_nxt   = 1'b0;
            state_nxt = ST_DONE;
          end else if (plane_r == fbc_pkg::PLANE_IDX_W'(fbc_pkg::ACTIVE_PLANES - 1)) begin
            vis_nxt   = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            plane_nxt = plane_r + fbc_pkg::PLANE_IDX_W'(1);
          end
        end else begin
          term_nxt = term_r + fbc_pkg::TERM_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_visible_nxt = vis_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      plane_r       <= '0;
      term_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      plane_r       <= plane_nxt;
      term_r        <= term_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    acc_r         <= acc_nxt;
    prod_r        <= prod_nxt;
    nz_r          <= nz_nxt;
    vis_r         <= vis_nxt;
    out_visible_r <= out_visible_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_accept && (in_ch.req_type == fbc_pkg::REQ_TEST)) begin
      lo_r[0] <= in_ch.box_min_x;
      lo_r[1] <= in_ch.box_min_y;
      lo_r[2] <= in_ch.box_min_z;
      hi_r[0] <= in_ch.box_max_x;
      hi_r[1] <= in_ch.box_max_y;
      hi_r[2] <= in_ch.box_max_z;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.visible = out_visible_r;

`ifndef ASSERT_OFF
  a_test_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_ch.req_type == fbc_pkg::REQ_TEST)) |=>
      (state_r == ST_RUN && plane_r == '0 && term_r == '0))
    else $error("box test did not start at the first plane");

  a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (term_r <= fbc_pkg::TERM_LAST))
    else $error("term counter out of range");

  a_post_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result posted outside the done state");
`endif

endmodule

/* sv/fbc_coef_store.sv */
// Plane coefficient registers, loaded one clip matrix column at a time.
module fbc_coef_store (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [fbc_pkg::COL_IDX_W-1:0]    wr_col,
  input  fbc_pkg::entry_t                  wr_entry [fbc_pkg::NUM_COEFS],
  input  logic [fbc_pkg::PLANE_IDX_W-1:0]  rd_plane,
  input  logic [fbc_pkg::COL_IDX_W-1:0]    rd_term,
  output fbc_pkg::coef_t                   rd_coef
);

  fbc_pkg::coef_t coef_r [fbc_pkg::ACTIVE_PLANES][fbc_pkg::NUM_COEFS];
  fbc_pkg::coef_t load_val [fbc_pkg::ACTIVE_PLANES];

  always_comb begin
    for (int p = 0; p < fbc_pkg::ACTIVE_PLANES; p++) begin
      if (fbc_pkg::plane_add(p)) begin
        load_val[p] = fbc_pkg::COEF_W'(wr_entry[3])
                    + fbc_pkg::COEF_W'(wr_entry[fbc_pkg::plane_row(p)]);
      end else begin
        load_val[p] = fbc_pkg::COEF_W'(wr_entry[3])
                    - fbc_pkg::COEF_W'(wr_entry[fbc_pkg::plane_row(p)]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < fbc_pkg::ACTIVE_PLANES; p++) begin
        for (int j = 0; j < fbc_pkg::NUM_COEFS; j++) begin
          coef_r[p][j] <= '0;
        end
      end
    end else if (wr_en) begin
      for (int p = 0; p < fbc_pkg::ACTIVE_PLANES; p++) begin
        coef_r[p][wr_col] <= load_val[p];
      end
    end
  end

  assign rd_coef = coef_r[rd_plane][rd_term];

endmodule

/* bench/tb_frustum_box_cull.sv */
// Testbench for frustum_box_cull: predicts plane loads and box tests, checks each visible word.
`timescale 1ns / 100ps

module tb_frustum_box_cull;

  localparam int              QUIET_LIMIT = 2000;
  localparam int              SETTLE      = 40;
  localparam fbc_pkg::entry_t ONE         = 32'sd65536;
  localparam fbc_pkg::entry_t E_MAX       = 32'h7FFF_FFFF;
  localparam fbc_pkg::entry_t E_MIN       = 32'h8000_0000;

  typedef struct packed {
    logic            req_type;
    logic [1:0]      column_index;
    fbc_pkg::entry_t col_entry_0;
    fbc_pkg::entry_t col_entry_1;
    fbc_pkg::entry_t col_entry_2;
    fbc_pkg::entry_t col_entry_3;
    fbc_pkg::coord_t box_min_x;
    fbc_pkg::coord_t box_min_y;
    fbc_pkg::coord_t box_min_z;
    fbc_pkg::coord_t box_max_x;
    fbc_pkg::coord_t box_max_y;
    fbc_pkg::coord_t box_max_z;
  } cull_req_t;

  logic clk;
  logic rst_n;
  bit   steady;
  int   quiet_cycles;
  int   fail_count;
  int   n_loads;
  int   n_tests;
  int   n_visible;
  int   n_culled;
  logic want_visible;
  logic visible_q[$];
  fbc_pkg::coef_t plane_coef [fbc_pkg::ACTIVE_PLANES][fbc_pkg::NUM_COEFS];

  fbc_in_if  in_ch ();
  fbc_out_if out_ch ();

  frustum_box_cull dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Coefficient j of plane p is w plus or minus row p/2 of column j.
  function automatic void apply_column(input cull_req_t r);
    fbc_pkg::entry_t row [4];
    longint w;
    longint e;
    row[0] = r.col_entry_0;
    row[1] = r.col_entry_1;
    row[2] = r.col_entry_2;
    row[3] = r.col_entry_3;
    w = row[3];
    for (int p = 0; p < fbc_pkg::ACTIVE_PLANES; p++) begin
      e = row[p / 2];
      case (p)
        1, 2, 5: plane_coef[p][r.column_index] = fbc_pkg::coef_t'(w + e);
        default: plane_coef[p][r.column_index] = fbc_pkg::coef_t'(w - e);
      endcase
    end
  endfunction

  function automatic logic box_visible(input cull_req_t r);
    longint lo [3];
    longint hi [3];
    longint a, b, c, d, x, y, z;
    logic   hit;
    lo[0] = r.box_min_x;
    lo[1] = r.box_min_y;
    lo[2] = r.box_min_z;
    hi[0] = r.box_max_x;
    hi[1] = r.box_max_y;
    hi[2] = r.box_max_z;
    for (int p = 0; p < fbc_pkg::ACTIVE_PLANES; p++) begin
      a = plane_coef[p][0];
      b = plane_coef[p][1];
      c = plane_coef[p][2];
      d = plane_coef[p][3];
      if (a == 0 && b == 0 && c == 0) return 1'b0;
      hit = 1'b0;
      for (int k = 0; k < 8; k++) begin
        x = k[0] ? lo[0] : hi[0];
        y = k[1] ? lo[1] : hi[1];
        z = k[2] ? lo[2] : hi[2];
        if (a * x + b * y + c * z + d > 0) hit = 1'b1;
      end
      if (!hit) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic cull_req_t load_word(input logic [1:0] col,
                                          input fbc_pkg::entry_t r0, r1, r2, r3);
    cull_req_t w;
    w = '0;
    w.req_type     = fbc_pkg::REQ_LOAD;
    w.column_index = col;
    w.col_entry_0  = r0;
    w.col_entry_1  = r1;
    w.col_entry_2  = r2;
    w.col_entry_3  = r3;
    return w;
  endfunction

  function automatic cull_req_t box_word(input int x0, y0, z0, x1, y1, z1);
    cull_req_t w;
    w = '0;
    w.req_type  = fbc_pkg::REQ_TEST;
    w.box_min_x = fbc_pkg::coord_t'(x0);
    w.box_min_y = fbc_pkg::coord_t'(y0);
    w.box_min_z = fbc_pkg::coord_t'(z0);
    w.box_max_x = fbc_pkg::coord_t'(x1);
    w.box_max_y = fbc_pkg::coord_t'(y1);
    w.box_max_z = fbc_pkg::coord_t'(z1);
    return w;
  endfunction

  // A perturbed view matrix column: unit diagonal, translation and a positive w scale.
  function automatic cull_req_t frame_column(input logic [1:0] col);
    fbc_pkg::entry_t r [4];
    for (int k = 0; k < 4; k++)
      r[k] = fbc_pkg::entry_t'(int'($urandom_range(32768)) - 16384);
    if (col == 2'd3) begin
      for (int k = 0; k < 3; k++)
        r[k] = fbc_pkg::entry_t'(int'($urandom_range(524288)) - 262144);
      r[3] = fbc_pkg::entry_t'($urandom_range(8, 64) * 65536);
    end else begin
      r[col] = r[col] + ONE;
    end
    return load_word(col, r[0], r[1], r[2], r[3]);
  endfunction

  function automatic cull_req_t rand_box(input bit full);
    int lo [3];
    int hi [3];
    int ext;
    for (int k = 0; k < 3; k++) begin
      if (full) begin
        lo[k] = int'($urandom_range(65535)) - 32768;
        hi[k] = int'($urandom_range(65535)) - 32768;
      end else begin
        lo[k] = int'($urandom_range(200)) - 100;
        ext   = $urandom_range(40);
        hi[k] = ($urandom_range(7) == 0) ? lo[k] - ext : lo[k] + ext;
      end
    end
    return box_word(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  task automatic send_word(input cull_req_t r);
    if (!steady && $urandom_range(99) < 37) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 37);
    end
    in_ch.req_type     <= r.req_type;
    in_ch.column_index <= r.column_index;
    in_ch.col_entry_0  <= r.col_entry_0;
    in_ch.col_entry_1  <= r.col_entry_1;
    in_ch.col_entry_2  <= r.col_entry_2;
    in_ch.col_entry_3  <= r.col_entry_3;
    in_ch.box_min_x    <= r.box_min_x;
    in_ch.box_min_y    <= r.box_min_y;
    in_ch.box_min_z    <= r.box_min_z;
    in_ch.box_max_x    <= r.box_max_x;
    in_ch.box_max_y    <= r.box_max_y;
    in_ch.box_max_z    <= r.box_max_z;
    in_ch.valid        <= 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (r.req_type == fbc_pkg::REQ_LOAD) begin
      apply_column(r);
      n_loads++;
    end else begin
      visible_q.push_back(box_visible(r));
      n_tests++;
    end
  endtask

  task automatic test_reset_planes;
    send_word(box_word(0, 0, 0, 0, 0, 0));
    send_word(box_word(-32768, -32768, -32768, 32767, 32767, 32767));
  endtask

  task automatic test_identity_frustum;
    send_word(load_word(2'd0, ONE, 0, 0, 0));
    send_word(load_word(2'd1, 0, ONE, 0, 0));
    send_word(load_word(2'd2, 0, 0, ONE, 0));
    send_word(load_word(2'd3, 0, 0, 0, ONE));
    send_word(box_word(0, 0, 0, 0, 0, 0));
    send_word(box_word(2, 0, 0, 5, 0, 0));
    send_word(box_word(1, 0, 0, 3, 0, 0));
    send_word(box_word(5, 5, 5, -5, -5, -5));
    send_word(box_word(-32768, -32768, -32768, 32767, 32767, 32767));
  endtask

  task automatic test_extreme_entries;
    send_word(load_word(2'd0, E_MAX, E_MIN, E_MAX, E_MIN));
    send_word(load_word(2'd1, E_MIN, E_MAX, E_MIN, E_MAX));
    send_word(load_word(2'd2, E_MAX, E_MAX, E_MIN, E_MIN));
    send_word(load_word(2'd3, E_MIN, E_MIN, E_MAX, E_MAX));
    send_word(box_word(-32768, -32768, -32768, 32767, 32767, 32767));
    send_word(box_word(32767, 32767, 32767, -32768, -32768, -32768));
    send_word(box_word(0, 0, 0, 0, 0, 0));
  endtask

  // Every plane gets a zero normal with a positive offset, so every box is culled.
  task automatic test_zero_normal;
    send_word(load_word(2'd0, 0, 0, 0, 0));
    send_word(load_word(2'd1, 0, 0, 0, 0));
    send_word(load_word(2'd2, 0, 0, 0, 0));
    send_word(load_word(2'd3, 0, 0, 0, ONE));
    send_word(box_word(0, 0, 0, 0, 0, 0));
    send_word(box_word(-32768, -32768, -32768, 32767, 32767, 32767));
  endtask

  task automatic test_random_traffic(input int n_words);
    int sent;
    int first;
    int nbox;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(99) < 80) begin
        first = $urandom_range(3);
        for (int j = 0; j < 4; j++) send_word(frame_column(2'((first + j) % 4)));
        nbox = $urandom_range(3, 10);
        repeat (nbox) send_word(rand_box($urandom_range(9) == 0));
        sent += 4 + nbox;
      end else begin
        if ($urandom_range(1) == 1)
          send_word(load_word(2'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom));
        else
          send_word(rand_box(1'b1));
        sent++;
      end
    end
  endtask

  task automatic test_back_to_back;
    steady = 1'b1;
    test_random_traffic(120);
    steady = 1'b0;
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= steady || ($urandom_range(99) >= 37);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (visible_q.size() == 0) begin
        $error("visible: no result expected, got %0b", out_ch.visible);
        fail_count++;
      end else begin
        want_visible = visible_q.pop_front();
        if (out_ch.visible !== want_visible) begin
          $error("visible: expected %0b, got %0b", want_visible, out_ch.visible);
          fail_count++;
        end
        if (want_visible) n_visible++;
        else n_culled++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Timed out after %0d cycles without a handshake.", QUIET_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    rst_n              = 1'b0;
    steady             = 1'b0;
    quiet_cycles       = 0;
    fail_count         = 0;
    in_ch.valid        = 1'b0;
    in_ch.req_type     = fbc_pkg::REQ_LOAD;
    in_ch.column_index = '0;
    in_ch.col_entry_0  = '0;
    in_ch.col_entry_1  = '0;
    in_ch.col_entry_2  = '0;
    in_ch.col_entry_3  = '0;
    in_ch.box_min_x    = '0;
    in_ch.box_min_y    = '0;
    in_ch.box_min_z    = '0;
    in_ch.box_max_x    = '0;
    in_ch.box_max_y    = '0;
    in_ch.box_max_z    = '0;
    for (int p = 0; p < fbc_pkg::ACTIVE_PLANES; p++)
      for (int j = 0; j < fbc_pkg::NUM_COEFS; j++) plane_coef[p][j] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_planes();
    test_identity_frustum();
    test_extreme_entries();
    test_zero_normal();
    test_random_traffic(420);
    test_back_to_back();
    test_random_traffic(80);

    in_ch.valid <= 1'b0;
    while (visible_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Loaded %0d matrix columns and tested %0d boxes, with and without stalls.",
             n_loads, n_tests);
    $display("Checked %0d visible and %0d culled results.", n_visible, n_culled);
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
